[rtl/gdw_pkg.sv]
// Package for the graph depth-first walk engine.
// Shared constants, status codes and the front-to-back command type.
`timescale 1ns / 1ps
package gdw_pkg;
  localparam int NODE_COUNT_DEF = 16;
  localparam int EDGE_COUNT_DEF = 64;
  localparam int NODE_W = 4;
  localparam int STATUS_W = 2;

  localparam logic [STATUS_W-1:0] ST_VISIT = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ADDED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DROP  = 2'd2;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_WALK = 1'b1;

  typedef struct packed {
    logic              op;
    logic [NODE_W-1:0] src;
    logic [NODE_W-1:0] dst;
    logic              bad;
  } cmd_t;
endpackage

[rtl/graph_dfs_walk_engine_core.sv]
// Top level of the graph depth-first walk engine.
// Depends on gdw_pkg, gdw_front and gdw_back.
`timescale 1ns / 1ps
// Queue-style ports on both sides. An add-edge item is handled in the back end
// and gives one status result. A walk starts when its command is taken, then
// pops nodes and scans each popped node's edge list through the registered single
// read port of the edge store, stalling whenever the result side is full, and gives
// at most NODE_COUNT results per walk. A two-entry command queue and a two-entry
// result queue decouple the back end from both neighbors.
module graph_dfs_walk_engine_core #(
  parameter int NODE_COUNT = gdw_pkg::NODE_COUNT_DEF,
  parameter int EDGE_COUNT = gdw_pkg::EDGE_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic                         operation,
  input  logic [gdw_pkg::NODE_W-1:0]   from_node,
  input  logic [gdw_pkg::NODE_W-1:0]   to_node,
  output logic                         empty,
  input  logic                         pop,
  output logic [gdw_pkg::STATUS_W-1:0] status,
  output logic [gdw_pkg::NODE_W-1:0]   node,
  output logic                         last
);
  import gdw_pkg::*;
  cmd_t cmd;
  logic cmd_valid, cmd_take;

  gdw_front #(.NODE_COUNT(NODE_COUNT)) u_front (
    .clk, .rst, .push, .full, .operation, .from_node, .to_node,
    .cmd_valid, .cmd, .cmd_take
  );
  gdw_back #(.NODE_COUNT(NODE_COUNT), .EDGE_COUNT(EDGE_COUNT)) u_back (
    .clk, .rst, .cmd_valid, .cmd, .cmd_take, .empty, .pop, .status, .node, .last
  );
endmodule

[rtl/gdw_front.sv]
// Front end: accepts items, flags out-of-range node ids, holds a short command queue.
// Depends on gdw_pkg.
`timescale 1ns / 1ps
module gdw_front #(
  parameter int NODE_COUNT = gdw_pkg::NODE_COUNT_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  logic                      operation,
  input  logic [gdw_pkg::NODE_W-1:0] from_node,
  input  logic [gdw_pkg::NODE_W-1:0] to_node,
  output logic                      cmd_valid,
  output gdw_pkg::cmd_t             cmd,
  input  logic                      cmd_take
);
  import gdw_pkg::*;
  cmd_t q [2];
  logic [1:0] cnt;
  logic rd, wr;
  logic bad;

  assign full = (cnt == 2'd2);
  assign cmd_valid = (cnt != 2'd0);
  assign cmd = q[rd];
  assign bad = ({1'b0, from_node} >= (NODE_W+1)'(NODE_COUNT)) ||
               ((operation == OP_ADD) && ({1'b0, to_node} >= (NODE_W+1)'(NODE_COUNT)));

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      rd <= 1'b0;
      wr <= 1'b0;
    end else begin
      if (push && !full) begin
        q[wr] <= '{op: operation, src: from_node, dst: to_node, bad: bad};
        wr <= ~wr;
      end
      if (cmd_take && cmd_valid) rd <= ~rd;
      cnt <= cnt + 2'((push && !full) ? 1 : 0) - 2'((cmd_take && cmd_valid) ? 1 : 0);
    end
  end
endmodule

[rtl/gdw_back.sv]
// Back end: edge store, adjacency lists, seen marks and the walk sequencer.
// Depends on gdw_pkg; feeds a two-entry result queue.
`timescale 1ns / 1ps
module gdw_back #(
  parameter int NODE_COUNT = gdw_pkg::NODE_COUNT_DEF,
  parameter int EDGE_COUNT = gdw_pkg::EDGE_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cmd_valid,
  input  gdw_pkg::cmd_t               cmd,
  output logic                        cmd_take,
  output logic                        empty,
  input  logic                        pop,
  output logic [gdw_pkg::STATUS_W-1:0] status,
  output logic [gdw_pkg::NODE_W-1:0]   node,
  output logic                        last
);
  import gdw_pkg::*;
  localparam int EW = $clog2(EDGE_COUNT);
  localparam int LW = EW + 1;
  localparam int NI = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int SW = $clog2(NODE_COUNT + 1);
  localparam logic [LW-1:0] NIL = LW'(EDGE_COUNT);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_POP  = 3'd1;
  localparam logic [2:0] S_EMIT = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_CHK  = 3'd4;

  // edge store memory; the last edge of a list is known from the tail, so its
  // link entry is never used
  logic [NODE_W-1:0] etgt [EDGE_COUNT];
  logic [LW-1:0]     elnk [EDGE_COUNT];
  logic [NODE_W-1:0] rd_tgt;
  logic [LW-1:0]     rd_lnk;
  logic [LW-1:0]     head [NODE_COUNT];
  logic [LW-1:0]     tail [NODE_COUNT];
  logic [NODE_COUNT-1:0] seen;
  logic [NODE_W-1:0] stk [NODE_COUNT];
  logic [SW-1:0]     top;
  logic [LW-1:0]     used;
  logic [2:0]        state;
  logic [LW-1:0]     e;
  logic [NODE_W-1:0] cur;
  logic [SW-1:0]     cnt;

  // result queue
  logic [STATUS_W+NODE_W:0] rq [2];
  logic [1:0] rc;
  logic rr, rw;
  logic rq_room;
  logic res_we;
  logic [STATUS_W+NODE_W:0] res;

  logic [NI-1:0] si, ci, ti;
  logic [NODE_W-1:0] top_node;
  logic [LW-1:0] pop_head;
  logic walk_done;
  logic add_we;

  assign rq_room = (rc != 2'd2);
  assign empty = (rc == 2'd0);
  assign {status, node, last} = rq[rr];

  assign si = NI'(cmd.src);
  assign ci = NI'(cur);
  assign ti = NI'(rd_tgt);
  assign top_node = stk[NI'(top - 1'b1)];
  assign pop_head = head[NI'(top_node)];
  assign walk_done = (top == '0) || (cnt == SW'(NODE_COUNT));
  assign add_we = (state == S_IDLE) && cmd_take && (cmd.op == OP_ADD) && !cmd.bad &&
                  (used != NIL);

  always_comb begin
    cmd_take = 1'b0;
    res_we = 1'b0;
    res = '0;
    if (state == S_IDLE && cmd_valid && rq_room) begin
      cmd_take = 1'b1;
      if (cmd.op == OP_ADD) begin
        res_we = 1'b1;
        res = {(cmd.bad || used == NIL) ? ST_DROP : ST_ADDED, {NODE_W{1'b0}}, 1'b1};
      end else if (cmd.bad) begin
        res_we = 1'b1;
        res = {ST_VISIT, cmd.src, 1'b1};
      end
    end
    // emit once the scan of the popped node's list is over
    if (state == S_EMIT && rq_room) begin
      res_we = 1'b1;
      res = {ST_VISIT, cur, walk_done};
    end
  end

  always_ff @(posedge clk) begin
    rd_tgt <= etgt[e[EW-1:0]];
    rd_lnk <= elnk[e[EW-1:0]];
    if (add_we) begin
      etgt[used[EW-1:0]] <= cmd.dst;
      if (tail[si] != NIL) elnk[tail[si][EW-1:0]] <= used;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      used <= '0;
      seen <= '0;
      top <= '0;
      cnt <= '0;
      e <= NIL;
      cur <= '0;
      for (int i = 0; i < NODE_COUNT; i++) begin
        head[i] <= NIL;
        tail[i] <= NIL;
        stk[i] <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (add_we) begin
            if (tail[si] == NIL) head[si] <= used;
            tail[si] <= used;
            used <= used + 1'b1;
          end else if (cmd_take && cmd.op == OP_WALK && !cmd.bad) begin
            seen[si] <= 1'b1;
            stk[0] <= cmd.src;
            top <= SW'(1);
            cnt <= '0;
            state <= S_POP;
          end
        end
        S_POP: begin
          cur <= top_node;
          top <= top - 1'b1;
          cnt <= cnt + 1'b1;
          e <= pop_head;
          state <= (pop_head == NIL) ? S_EMIT : S_RD;
        end
        S_RD: begin
          // wait for the registered read of edge e
          state <= S_CHK;
        end
        S_CHK: begin
          if (!seen[ti] && top < SW'(NODE_COUNT)) begin
            seen[ti] <= 1'b1;
            stk[NI'(top)] <= rd_tgt;
            top <= top + 1'b1;
          end
          if (e == tail[ci]) begin
            state <= S_EMIT;
          end else begin
            e <= rd_lnk;
            state <= S_RD;
          end
        end
        S_EMIT: begin
          if (rq_room) begin
            if (walk_done) begin
              top <= '0;
              state <= S_IDLE;
            end else begin
              state <= S_POP;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rc <= '0;
      rr <= 1'b0;
      rw <= 1'b0;
    end else begin
      if (res_we) begin
        rq[rw] <= res;
        rw <= ~rw;
      end
      if (pop && !empty) rr <= ~rr;
      rc <= rc + 2'(res_we ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
    end
  end
endmodule

[rtl/gdw_checker.sv]
// Port-level checks for the walk engine, bound to the top level.
// Depends on gdw_pkg.
`timescale 1ns / 1ps
module gdw_checker (
  input logic       clk,
  input logic       rst,
  input logic       empty,
  input logic       pop,
  input logic [1:0] status,
  input logic [3:0] node,
  input logic       last
);
  import gdw_pkg::*;
  a_status: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (status == ST_VISIT || status == ST_ADDED || status == ST_DROP))
    else $error("bad status");
  a_edge_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && status != ST_VISIT) |-> last)
    else $error("edge result not last");
  a_edge_node: assert property (@(posedge clk) disable iff (rst)
    (!empty && status != ST_VISIT) |-> node == '0)
    else $error("edge result with node");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(node)))
    else $error("result changed while waiting");
endmodule

bind graph_dfs_walk_engine_core gdw_checker u_chk (
  .clk, .rst, .empty, .pop, .status, .node, .last
);
